### src/planar_tile_decoder_core_macros.svh
// Assertion macros for the planar tile decoder checker.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef PLANAR_TILE_DECODER_CORE_MACROS_SVH
`define PLANAR_TILE_DECODER_CORE_MACROS_SVH

// Same-cycle implication, off while reset is held
`define PTD_ASSERT_IMPL(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ptd check failed");

// Next-cycle implication, off while reset is held
`define PTD_ASSERT_NEXT(name, ante, cons) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ptd check failed");

// Next-cycle implication that also watches reset itself
`define PTD_ASSERT_RESET(name, ante, cons) \
    name: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("ptd check failed");

`endif

### src/ptd_pkg.sv
// Shared types and constants of the planar tile decoder.
// No dependencies; every other file but the assertion macro header imports this package.
package ptd_pkg;

    // Field widths
    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int MODE_W   = 2;
    localparam int TILE_W   = 12;
    localparam int ROW_W    = 3;
    localparam int PLANE_W  = 3;
    localparam int NUM_PIX  = 8;

    // Default memory size and command queue depth (power of two)
    localparam int MEM_ADDR_BITS_DEF = 16;
    localparam int QUEUE_DEPTH       = 2;

    // Item actions
    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_DECODE = 1'b1;

    // Depth modes
    localparam logic [MODE_W-1:0] MODE_2BPP = 2'd0;
    localparam logic [MODE_W-1:0] MODE_4BPP = 2'd1;
    localparam logic [MODE_W-1:0] MODE_8BPP = 2'd2;
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;

    localparam logic [ROW_W-1:0] LAST_ROW = 3'd7;

    // Classified command between front and back
    typedef struct packed {
        logic              kind;   // ACT_WRITE or ACT_DECODE
        logic [ADDR_W-1:0] addr;   // write address or tile base address
        logic [DATA_W-1:0] data;
        logic [MODE_W-1:0] mode;
    } t_cmd;

    typedef logic [NUM_PIX-1:0][DATA_W-1:0] t_pix_row;

endpackage

### src/ptd_if.sv
// Channel interfaces of the planar tile decoder: input items and row results.
// Depends on ptd_pkg.
interface ptd_in_if import ptd_pkg::*; ();
    logic                valid;
    logic                ready;
    logic                action;
    logic [ADDR_W-1:0]   mem_address;
    logic [DATA_W-1:0]   mem_data;
    logic [MODE_W-1:0]   depth_mode;
    logic [TILE_W-1:0]   tile_index;

    modport source (output valid, action, mem_address, mem_data, depth_mode, tile_index,
                    input ready);
    modport sink   (input valid, action, mem_address, mem_data, depth_mode, tile_index,
                    output ready);
endinterface

interface ptd_out_if import ptd_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [ROW_W-1:0]   row_number;
    logic [DATA_W-1:0]  pixel_0;
    logic [DATA_W-1:0]  pixel_1;
    logic [DATA_W-1:0]  pixel_2;
    logic [DATA_W-1:0]  pixel_3;
    logic [DATA_W-1:0]  pixel_4;
    logic [DATA_W-1:0]  pixel_5;
    logic [DATA_W-1:0]  pixel_6;
    logic [DATA_W-1:0]  pixel_7;
    logic               last_row;

    modport source (output valid, row_number, pixel_0, pixel_1, pixel_2, pixel_3,
                    pixel_4, pixel_5, pixel_6, pixel_7, last_row,
                    input ready);
    modport sink   (input valid, row_number, pixel_0, pixel_1, pixel_2, pixel_3,
                    pixel_4, pixel_5, pixel_6, pixel_7, last_row,
                    output ready);
endinterface

### src/planar_tile_decoder_core.sv
// Top level of the planar tile decoder: front end, command queue, back end.
// Depends on ptd_pkg, ptd_if, ptd_front, ptd_queue and ptd_back.
//
// The decoder keeps its own byte-wide video memory of 2**MEM_ADDR_BITS bytes
// (single port, registered read). A write beat stores one byte in the back
// end and gives no result. A decode beat of a 2, 4 or 8 bpp tile
// gives eight result beats, rows 0 to 7, each with eight chunky color indices
// and last_row set on row 7; a decode in depth mode 3 is taken and gives
// nothing. The back end reads one plane byte per cycle from the memory port,
// 16, 32 or 64 bytes per tile for 2, 4 or 8 bpp; the last read of a row
// waits only while the receiver holds a finished row in the output register.
// Input beats are taken into a two-entry command queue while the back end
// works, and a finished row waits in the output register until taken.
// Memory contents are undefined after reset until written; no clearing pass
// runs.
module planar_tile_decoder_core import ptd_pkg::*; #(
    parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ptd_in_if.sink      i_in,
    ptd_out_if.source   o_out
);

    logic push;
    t_cmd push_cmd;
    logic q_full;
    logic head_valid;
    t_cmd head_cmd;
    logic pop;

    ptd_front u_front (
        .i_in     (i_in),
        .i_q_full (q_full),
        .o_push   (push),
        .o_cmd    (push_cmd)
    );

    ptd_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_push_cmd   (push_cmd),
        .o_full       (q_full),
        .o_head_valid (head_valid),
        .o_head_cmd   (head_cmd),
        .i_pop        (pop)
    );

    ptd_back #(
        .MEM_ADDR_BITS (MEM_ADDR_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head_cmd   (head_cmd),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule

### src/ptd_front.sv
// Front end: accepts input beats, drops unused-mode decodes, builds commands.
// Depends on ptd_pkg and ptd_if.
module ptd_front import ptd_pkg::*; (
    ptd_in_if.sink      i_in,
    input  logic        i_q_full,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic              is_drop;
    logic [ADDR_W-1:0] tile_base;

    // Accept whenever the queue has room
    assign i_in.ready = !i_q_full;

    // Mask the tile number to the mode's tile count and scale by tile size
    always_comb begin
        unique case (i_in.depth_mode)
            MODE_2BPP: tile_base = {i_in.tile_index, 4'b0000};
            MODE_4BPP: tile_base = {i_in.tile_index[TILE_W-2:0], 5'b00000};
            MODE_8BPP: tile_base = {i_in.tile_index[TILE_W-3:0], 6'b000000};
            MODE_NONE: tile_base = '0;
        endcase
    end

    // Classify the beat; an unused-mode decode is taken and dropped
    assign is_drop = (i_in.action == ACT_DECODE) && (i_in.depth_mode == MODE_NONE);
    assign o_push  = i_in.valid && !i_q_full && !is_drop;

    always_comb begin
        o_cmd.kind = i_in.action;
        o_cmd.addr = (i_in.action == ACT_WRITE) ? i_in.mem_address : tile_base;
        o_cmd.data = i_in.mem_data;
        o_cmd.mode = i_in.depth_mode;
    end

endmodule

### src/ptd_queue.sv
// Short command queue between the front end and the back end.
// Depends on ptd_pkg; depth is QUEUE_DEPTH, a power of two.
module ptd_queue import ptd_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_push_cmd,
    output logic o_full,
    output logic o_head_valid,
    output t_cmd o_head_cmd,
    input  logic i_pop
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    t_cmd             r_slot [QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_full       = (r_count == CNT_W'(QUEUE_DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head_cmd   = r_slot[r_rd_ptr];

    // Advance pointers; they wrap on their own since the depth is a power of two
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store the pushed command
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_push_cmd;
        end
    end

endmodule

### src/ptd_back.sv
// Back end: owns the video memory, runs writes and tile decodes, and holds
// the output register. Depends on ptd_pkg and ptd_if.
module ptd_back import ptd_pkg::*; #(
    parameter int MEM_ADDR_BITS = MEM_ADDR_BITS_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_head_valid,
    input  t_cmd          i_head_cmd,
    output logic          o_pop,
    ptd_out_if.source     o_out
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_DEC  = 1'b1;

    // Video memory, single port, registered read
    logic [DATA_W-1:0]        r_vram [2**MEM_ADDR_BITS];
    logic [DATA_W-1:0]        r_rdata;
    logic [MEM_ADDR_BITS-1:0] mem_addr;
    logic                     mem_we;

    // Sequencer
    logic               r_state;
    logic [ADDR_W-1:0]  r_base;
    logic [MODE_W-1:0]  r_mode;
    logic [ROW_W-1:0]   r_row;
    logic [PLANE_W-1:0] r_plane;
    logic               r_issue_done;

    // Read in flight
    logic               r_infl_valid;
    logic [ROW_W-1:0]   r_infl_row;
    logic [PLANE_W-1:0] r_infl_plane;
    logic               r_infl_last;

    // Row accumulator and output register
    t_pix_row           r_acc;
    t_pix_row           pix_new;
    logic               r_out_valid;
    logic [ROW_W-1:0]   r_out_row;
    t_pix_row           r_out_pix;

    logic [PLANE_W-1:0] plane_max;
    logic               is_last;
    logic               out_free;
    logic               can_issue;
    logic [ADDR_W-1:0]  rd_addr;
    logic               row_done;

    // Plane count is 2, 4 or 8 by mode
    assign plane_max = PLANE_W'((4'd2 << r_mode) - 4'd1);
    assign is_last   = (r_plane == plane_max);
    assign out_free  = !r_out_valid || o_out.ready;

    // The last read of a row may go out only when its row has a place to land
    assign can_issue = (r_state == ST_DEC) && !r_issue_done &&
                       (!is_last || (out_free && !(r_infl_valid && r_infl_last)));

    // Plane pair at 16-byte steps, odd plane next byte, row at 2-byte steps
    assign rd_addr = r_base + ADDR_W'({r_plane[2:1], r_row, r_plane[0]});

    // Take a queued command only when idle
    assign o_pop    = (r_state == ST_IDLE) && i_head_valid;
    assign mem_we   = o_pop && (i_head_cmd.kind == ACT_WRITE);
    assign mem_addr = mem_we ? i_head_cmd.addr[MEM_ADDR_BITS-1:0]
                             : rd_addr[MEM_ADDR_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_vram[mem_addr] <= i_head_cmd.data;
        end else begin
            r_rdata <= r_vram[mem_addr];
        end
    end

    // Merge the arriving plane byte: bit 7-k of the byte is bit plane of pixel k
    always_comb begin
        for (int k = 0; k < NUM_PIX; k++) begin
            pix_new[k] = ((r_infl_plane == '0) ? '0 : r_acc[k]) |
                         (DATA_W'(r_rdata[NUM_PIX-1-k]) << r_infl_plane);
        end
    end

    assign row_done = r_infl_valid && r_infl_last;

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_issue_done <= 1'b0;
            r_infl_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (o_pop && (i_head_cmd.kind == ACT_DECODE)) begin
                        r_state      <= ST_DEC;
                        r_issue_done <= 1'b0;
                    end
                end
                ST_DEC: begin
                    if (can_issue && is_last && (r_row == LAST_ROW)) begin
                        r_issue_done <= 1'b1;
                    end
                    if (r_issue_done && !r_infl_valid) begin
                        r_state <= ST_IDLE;
                    end
                end
            endcase
            r_infl_valid <= can_issue;
            if (row_done) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (o_pop && (i_head_cmd.kind == ACT_DECODE)) begin
            r_base  <= i_head_cmd.addr;
            r_mode  <= i_head_cmd.mode;
            r_row   <= '0;
            r_plane <= '0;
        end else if (can_issue) begin
            if (is_last) begin
                r_plane <= '0;
                r_row   <= r_row + 1'b1;
            end else begin
                r_plane <= r_plane + 1'b1;
            end
        end
        if (can_issue) begin
            r_infl_row   <= r_row;
            r_infl_plane <= r_plane;
            r_infl_last  <= is_last;
        end
        if (r_infl_valid) begin
            r_acc <= pix_new;
        end
        if (row_done) begin
            r_out_row <= r_infl_row;
            r_out_pix <= pix_new;
        end
    end

    // Drive the result channel
    assign o_out.valid      = r_out_valid;
    assign o_out.row_number = r_out_row;
    assign o_out.pixel_0    = r_out_pix[0];
    assign o_out.pixel_1    = r_out_pix[1];
    assign o_out.pixel_2    = r_out_pix[2];
    assign o_out.pixel_3    = r_out_pix[3];
    assign o_out.pixel_4    = r_out_pix[4];
    assign o_out.pixel_5    = r_out_pix[5];
    assign o_out.pixel_6    = r_out_pix[6];
    assign o_out.pixel_7    = r_out_pix[7];
    assign o_out.last_row   = (r_out_row == LAST_ROW);

endmodule

### src/ptd_checker.sv
// Port-level checks of the planar tile decoder, bound to the top level.
// Depends on ptd_pkg and planar_tile_decoder_core_macros.svh.
`include "planar_tile_decoder_core_macros.svh"

module ptd_checker import ptd_pkg::*; (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                i_out_valid,
    input logic                                i_out_ready,
    input logic [ROW_W-1:0]                    i_out_row,
    input logic                                i_out_last,
    input logic [NUM_PIX*DATA_W-1:0]           i_out_pix
);

    // Result beat held until taken
    `PTD_ASSERT_NEXT(a_out_hold, i_out_valid && !i_out_ready, i_out_valid)
    // Stalled result keeps its payload
    `PTD_ASSERT_NEXT(a_out_stable, i_out_valid && !i_out_ready, $stable(i_out_pix) && $stable(i_out_row))
    // Last-row flag marks row 7 only
    `PTD_ASSERT_IMPL(a_last_row, i_out_valid, i_out_last == (i_out_row == LAST_ROW))
    // Rows of a tile come out in order: a beat right after a taken non-last row carries the next row
    `PTD_ASSERT_NEXT(a_row_order, i_out_valid && i_out_ready && !i_out_last, !i_out_valid || (i_out_row == $past(i_out_row) + 3'd1))
    // Reset leaves no result pending
    `PTD_ASSERT_RESET(a_reset_quiet, !i_rst_n, !i_out_valid)

endmodule

bind planar_tile_decoder_core ptd_checker u_ptd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_row   (o_out.row_number),
    .i_out_last  (o_out.last_row),
    .i_out_pix   ({o_out.pixel_7, o_out.pixel_6, o_out.pixel_5, o_out.pixel_4,
                   o_out.pixel_3, o_out.pixel_2, o_out.pixel_1, o_out.pixel_0})
);
